[hw/rtl/eurs_pkg.sv]
package eurs_pkg;

	localparam int unsigned MAX_STEPS = 32;
	localparam int unsigned POS_W     = 5;
	localparam int unsigned CNT_W     = 6;
	localparam int unsigned ACC_W     = 12;
	localparam int unsigned CFG_W     = 6;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] MAX_STEPS_C = CNT_W'(MAX_STEPS);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FILL     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEPS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 2'd2;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_RESTART = 2'd1,
		OP_PEEK    = 2'd2,
		OP_NOP     = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_REDUCE,
		ST_BUILD
	} build_state_t;

	typedef struct packed {
		logic [CNT_W-1:0] fill_count;
		logic [CNT_W-1:0] step_count;
		logic [POS_W-1:0] rotation;
	} cfg_t;

	// step count clamped to the pattern storage
	function automatic logic [CNT_W-1:0] eff_steps(input logic [CNT_W-1:0] s);
		return (s > MAX_STEPS_C) ? MAX_STEPS_C : s;
	endfunction

endpackage

[hw/rtl/eurs_in_if.sv]
interface eurs_in_if
	import eurs_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [1:0]       opcode;
	logic [POS_W-1:0] peek_index;

	modport source (output valid, output opcode, output peek_index, input ready);
	modport sink   (input valid, input opcode, input peek_index, output ready);
endinterface

[hw/rtl/eurs_out_if.sv]
interface eurs_out_if
	import eurs_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             gate;
	logic [POS_W-1:0] step_index;

	modport source (output valid, output gate, output step_index, input ready);
	modport sink   (input valid, input gate, input step_index, output ready);
endinterface

[hw/rtl/eurs_pattern_gen.sv]
module eurs_pattern_gen
	import eurs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  cfg_t                 cfg,
	output logic                 busy,
	output logic [MAX_STEPS-1:0] pattern
);

	build_state_t state_q, state_d;

	logic [MAX_STEPS-1:0] pattern_q;
	logic [POS_W-1:0]     rmod_q;
	logic [POS_W-1:0]     j_q;
	logic [POS_W-1:0]     cell_q;
	logic [CNT_W-1:0]     k_q;
	logic [ACC_W-1:0]     acc_a_q;
	logic [ACC_W-1:0]     acc_b_q;

	logic [CNT_W-1:0] s_eff;
	logic [CNT_W-1:0] f_eff;
	logic             rmod_ge;
	logic             hit;
	logic             last_cell;
	logic [POS_W-1:0] cell_next;

	assign s_eff = eff_steps(cfg.step_count);
	assign f_eff = (cfg.fill_count > s_eff) ? s_eff : cfg.fill_count;

	// datapath decisions
	always_comb begin
		rmod_ge   = {1'b0, rmod_q} >= s_eff;
		// next hit k lands here when 2ks+f < 2f(j+1)
		hit       = (k_q < f_eff) && (acc_a_q < acc_b_q);
		last_cell = ({1'b0, j_q} == (s_eff - CNT_W'(1)));
		cell_next = ({1'b0, cell_q} == (s_eff - CNT_W'(1))) ? '0 : cell_q + POS_W'(1);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   state_d = ST_IDLE;
			ST_LOAD:   state_d = (s_eff == '0) ? ST_IDLE : ST_REDUCE;
			ST_REDUCE: state_d = rmod_ge ? ST_REDUCE : ST_BUILD;
			ST_BUILD:  state_d = last_cell ? ST_IDLE : ST_BUILD;
			default:   state_d = ST_IDLE;
		endcase
		if (start)
			state_d = ST_LOAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			rmod_q    <= '0;
			j_q       <= '0;
			k_q       <= '0;
			cell_q    <= '0;
			acc_a_q   <= '0;
			acc_b_q   <= '0;
		end else if (!start) begin
			unique case (state_q)
				ST_LOAD: begin
					pattern_q <= '0;
					rmod_q    <= cfg.rotation;
				end
				ST_REDUCE: begin
					if (rmod_ge) begin
						rmod_q <= rmod_q - s_eff[POS_W-1:0];
					end else begin
						j_q     <= '0;
						k_q     <= '0;
						cell_q  <= rmod_q;
						acc_a_q <= ACC_W'(f_eff);
						acc_b_q <= ACC_W'({f_eff, 1'b0});
					end
				end
				ST_BUILD: begin
					if (hit) begin
						pattern_q[cell_q] <= 1'b1;
						k_q               <= k_q + CNT_W'(1);
						acc_a_q           <= acc_a_q + ACC_W'({s_eff, 1'b0});
					end
					acc_b_q <= acc_b_q + ACC_W'({f_eff, 1'b0});
					j_q     <= j_q + POS_W'(1);
					cell_q  <= cell_next;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		busy    = (state_q != ST_IDLE);
		pattern = pattern_q;
	end

endmodule

[hw/rtl/euclidean_rhythm_sequencer.sv]
// An accepted item's result is written to the output register on the next clock edge.
// Throughput: one item per cycle while no rebuild runs; the output register lets
//   a new item in while the previous result is taken in the same cycle.
// A write to a mapped register rebuilds the pattern (load, reduce the rotation,
//   build each cell; zero steps end at the load), input stalled. Reset (arst_n low)
//   clears position and config to fill 0, steps 16, rotation 0: all-zero pattern.
module euclidean_rhythm_sequencer
	import eurs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	eurs_in_if.sink              in_ch,
	eurs_out_if.source           out_ch
);

	cfg_t                 cfg_q;
	logic                 cfg_hit;
	logic                 build_busy;
	logic [MAX_STEPS-1:0] pattern;

	logic [POS_W-1:0] pos_q;
	logic             out_valid_q;
	logic             gate_q;
	logic [POS_W-1:0] step_index_q;

	logic             in_acc;
	logic [CNT_W-1:0] s_eff;
	logic             res_gate;
	logic [POS_W-1:0] res_index;
	logic [POS_W-1:0] pos_next;
	opcode_t          op;

	// ---------------- configuration registers ----------------
	always_comb begin
		unique case (cfg_index)
			CFG_FILL, CFG_STEPS, CFG_ROTATION: cfg_hit = cfg_we;
			default:                           cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fill_count <= '0;
			cfg_q.step_count <= CNT_W'(16);
			cfg_q.rotation   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FILL:     cfg_q.fill_count <= cfg_data;
				CFG_STEPS:    cfg_q.step_count <= cfg_data;
				CFG_ROTATION: cfg_q.rotation   <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// pattern rebuild runs after every valid register write
	eurs_pattern_gen u_pattern_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cfg_hit),
		.cfg     (cfg_q),
		.busy    (build_busy),
		.pattern (pattern)
	);

	// ---------------- item path ----------------
	// stall while the pattern is rebuilt; otherwise take an item whenever the
	// result register is empty or being drained
	assign in_ch.ready = !build_busy && (!out_valid_q || out_ch.ready);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign s_eff       = eff_steps(cfg_q.step_count);
	assign op          = opcode_t'(in_ch.opcode);

	always_comb begin
		res_gate  = 1'b0;
		res_index = '0;
		pos_next  = pos_q;
		unique case (op)
			OP_TICK: begin
				// position may sit past a shrunken length: gate 0, then wrap
				res_gate  = ({1'b0, pos_q} < s_eff) ? pattern[pos_q] : 1'b0;
				res_index = pos_q;
				pos_next  = ((s_eff != '0) && (({1'b0, pos_q} + CNT_W'(1)) < s_eff))
				            ? pos_q + POS_W'(1) : '0;
			end
			OP_RESTART: pos_next = '0;
			OP_PEEK: begin
				res_gate  = ({1'b0, in_ch.peek_index} < s_eff)
				            ? pattern[in_ch.peek_index] : 1'b0;
				res_index = in_ch.peek_index;
			end
			default: ;  // no-op: zero result, state held
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				pos_q       <= pos_next;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			gate_q       <= res_gate;
			step_index_q <= res_index;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.gate       = gate_q;
	assign out_ch.step_index = step_index_q;

	// ---------------- checks ----------------
	a_stall_on_build: assert property (@(posedge clk) disable iff (!arst_n)
		build_busy |-> !in_ch.ready)
		else $error("item taken during pattern rebuild");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_ch.valid)
		else $error("accepted item produced no result");

	a_restart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == OP_RESTART) |=> (pos_q == '0 && !out_ch.gate))
		else $error("restart did not clear position");

	a_zero_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == OP_TICK && s_eff == '0) |=> (pos_q == '0 && !out_ch.gate))
		else $error("tick with zero steps misbehaved");

endmodule

[tb/tb_euclidean_rhythm_sequencer.sv]
module tb_euclidean_rhythm_sequencer
	import eurs_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// one result item as the block reports it
	typedef struct packed {
		logic             gate;
		logic [POS_W-1:0] step_index;
	} beat_t;

	// Keeps a private copy of the sequencer: registers, pattern and play
	// position. Each accepted item is played against it right away; the
	// resulting beat waits in a queue for the block's answer.
	class rhythm_scoreboard;
		logic [CNT_W-1:0]     fills;
		logic [CNT_W-1:0]     steps;
		logic [POS_W-1:0]     rot;
		logic [MAX_STEPS-1:0] pattern;
		logic [POS_W-1:0]     pos;
		beat_t                expected_beats[$];
		int                   errors;

		function new();
			fills   = '0;
			steps   = CNT_W'(16);
			rot     = '0;
			pos     = '0;
			errors  = 0;
			rebuild_pattern();
		endfunction

		function int unsigned live_steps();
			return (steps > MAX_STEPS) ? MAX_STEPS : int'(steps);
		endfunction

		// hit k lands on round-half-up of k*steps/fills, then rotate right
		function void rebuild_pattern();
			int unsigned s, f, r, p;
			s       = live_steps();
			pattern = '0;
			if (s == 0)
				return;
			f = (fills > s) ? s : int'(fills);
			r = int'(rot) % s;
			for (int unsigned k = 0; k < f; k++) begin
				p = (2 * k * s + f) / (2 * f);
				pattern[(p + r) % s] = 1'b1;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_FILL:     fills = data;
				CFG_STEPS:    steps = data;
				CFG_ROTATION: rot   = data[POS_W-1:0];
				default:      return;
			endcase
			rebuild_pattern();
		endfunction

		function logic cell_gate(logic [POS_W-1:0] i);
			return (int'(i) < live_steps()) ? pattern[i] : 1'b0;
		endfunction

		function void note_item(opcode_t op, logic [POS_W-1:0] pk);
			int unsigned s;
			beat_t       b;
			s = live_steps();
			b = '0;
			case (op)
				OP_TICK: begin
					b.gate       = cell_gate(pos);
					b.step_index = pos;
					if (s > 0 && int'(pos) + 1 < s)
						pos = pos + 1'b1;
					else
						pos = '0;
				end
				OP_RESTART: pos = '0;
				OP_PEEK: begin
					b.gate       = cell_gate(pk);
					b.step_index = pk;
				end
				default: ;
			endcase
			expected_beats.push_back(b);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic gate, logic [POS_W-1:0] idx);
			beat_t want;
			if (expected_beats.size() == 0) begin
				report($sformatf("unexpected result gate=%0b step_index=%0d", gate, idx));
				return;
			end
			want = expected_beats.pop_front();
			if (gate !== want.gate)
				report($sformatf("gate %0b, wanted %0b (step_index %0d)",
					gate, want.gate, want.step_index));
			if (idx !== want.step_index)
				report($sformatf("step_index %0d, wanted %0d", idx, want.step_index));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	eurs_in_if  in_ch ();
	eurs_out_if out_ch ();

	euclidean_rhythm_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	rhythm_scoreboard sb = new();

	// percent of cycles in which each side holds back; 0 during the calm stretch
	int idle_pct = 23;
	int items_played = 0;

	always #5 clk = ~clk;

	// Hard stop: far beyond the slowest legal run (items, rebuild stalls and random
	// back-pressure).
	initial begin
		#2ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// Result side: check every accepted beat, then choose next cycle's ready.
	// Values read right after the edge are the ones the edge sampled.
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.gate, out_ch.step_index);
			out_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	// Present one item after a random gap and hold it until accepted. Valid is
	// left high on return: the caller either follows with another item or drains,
	// so valid gets exactly one assignment in that step.
	task automatic send_item(input opcode_t op, input logic [POS_W-1:0] pk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.opcode     <= op;
		in_ch.peek_index <= pk;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_item(op, pk);
		items_played++;
	endtask

	// drop valid and wait for every outstanding beat to come back
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.expected_beats.size() != 0)
			@(posedge clk);
	endtask

	// Register write, only while idle. The block stalls its input during the
	// pattern rebuild, so a peek sent afterwards and its answer mark the end of
	// the rebuild before anything else is written.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
		send_item(OP_PEEK, POS_W'($urandom_range(0, 31)));
		drain();
	endtask

	initial begin : stimulus
		logic [CFG_W-1:0] steps_val, fill_val;
		int               roll, burst, phase;

		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= CFG_FILL;
		cfg_data         <= '0;
		in_ch.valid      <= 1'b0;
		in_ch.opcode     <= OP_NOP;
		in_ch.peek_index <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// reset pattern: 16 steps, no hits
		send_item(OP_TICK, 5'd0);
		send_item(OP_TICK, 5'd31);
		send_item(OP_PEEK, 5'd31);         // peek past the pattern end
		send_item(OP_NOP, 5'd31);          // no-op reports zeros
		send_item(OP_RESTART, 5'd31);      // restart reports zeros
		send_item(OP_TICK, 5'd0);
		drain();
		write_reg(CFG_FILL, 6'd40);        // more fills than steps: every cell a hit
		send_item(OP_TICK, 5'd0);
		drain();
		write_reg(CFG_STEPS, 6'd63);       // step count clamps to MAX_STEPS
		send_item(OP_PEEK, 5'd31);
		send_item(OP_PEEK, 5'd0);
		drain();
		write_reg(CFG_FILL, 6'd5);
		write_reg(CFG_STEPS, 6'd13);
		write_reg(CFG_ROTATION, 6'd63);    // top data bit falls outside the field
		repeat (3) send_item(OP_TICK, 5'd17);
		drain();
		write_reg(CFG_STEPS, 6'd3);        // play position now sits past the end
		send_item(OP_TICK, 5'd0);
		send_item(OP_PEEK, 5'd2);
		drain();
		write_reg(CFG_STEPS, 6'd0);        // empty pattern: gate 0, position pinned
		send_item(OP_TICK, 5'd0);
		send_item(OP_TICK, 5'd0);
		drain();
		write_reg(2'd3, 6'd63);            // unmapped register index

		// --- random phases ---
		// Each phase drains, rewrites some registers (extremes often), then plays
		// a burst. Ticks dominate so the position walks whole patterns.
		phase = 0;
		while (items_played < 1000) begin
			idle_pct = (phase >= 4 && phase <= 6) ? 0 : 23;
			drain();

			roll = $urandom_range(0, 9);
			case (roll)
				0:       steps_val = 6'd0;
				1:       steps_val = 6'd32;
				2:       steps_val = CFG_W'($urandom_range(33, 63));
				3:       steps_val = 6'd1;
				default: steps_val = CFG_W'($urandom_range(2, 31));
			endcase
			roll = $urandom_range(0, 7);
			case (roll)
				0:       fill_val = 6'd0;
				1:       fill_val = CFG_W'($urandom_range(0, 63));
				2:       fill_val = steps_val;
				default: fill_val = CFG_W'($urandom_range(1, (steps_val > 1) ? steps_val : 1));
			endcase

			if (phase == 0 || $urandom_range(0, 2) != 0)
				write_reg(CFG_STEPS, steps_val);
			if (phase == 0 || $urandom_range(0, 2) != 0)
				write_reg(CFG_FILL, fill_val);
			if ($urandom_range(0, 2) != 0)
				write_reg(CFG_ROTATION, CFG_W'($urandom_range(0, 63)));
			if ($urandom_range(0, 9) == 0)
				write_reg(2'd3, CFG_W'($urandom_range(0, 63)));

			burst = $urandom_range(20, 80);
			repeat (burst) begin
				roll = $urandom_range(0, 99);
				if (roll < 55)
					send_item(OP_TICK, POS_W'($urandom_range(0, 31)));
				else if (roll < 63)
					send_item(OP_RESTART, POS_W'($urandom_range(0, 31)));
				else if (roll < 92)
					send_item(OP_PEEK, POS_W'($urandom_range(0, 31)));
				else
					send_item(OP_NOP, POS_W'($urandom_range(0, 31)));
			end
			phase++;
		end

		// let the last beats land, then keep the clock running to catch strays
		idle_pct = 23;
		drain();
		repeat (5) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/eurs_pkg.sv
hw/rtl/eurs_in_if.sv
hw/rtl/eurs_out_if.sv
hw/rtl/eurs_pattern_gen.sv
hw/rtl/euclidean_rhythm_sequencer.sv
tb/tb_euclidean_rhythm_sequencer.sv
